// ===== src/tsi_pkg.sv =====
// tsi_pkg: widths, types and helpers shared by the trapezoid strip integral unit.
// Used by tsi_cfg_regs, tsi_div_pair and trapezoid_strip_integral_unit.
// No dependencies.
package tsi_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int REG_W      = DATA_WIDTH - 1;
	localparam int IDX_W      = 2;
	localparam int DEN_W      = REG_W;
	localparam int Q_W        = REG_W;
	localparam int NUM_W      = DEN_W + Q_W;
	localparam int WID_W      = DATA_WIDTH;
	localparam int FLAT_W     = REG_W + WID_W - FRAC_BITS;
	localparam int SUM_W      = FLAT_W + 1;
	localparam int SIDE_W     = 3 * REG_W + 4;
	localparam int RPAD_W     = SIDE_W - REG_W - FLAT_W;

	localparam logic [REG_W-1:0] REG_RESET = REG_W'(1) << FRAC_BITS;
	localparam logic signed [DATA_WIDTH-1:0] SMAX_D = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SMIN_D = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef enum logic [IDX_W-1:0] {
		REG_STRIP_WIDTH = 2'd0,
		REG_PIXEL_SIZE  = 2'd1,
		REG_NORM_GAIN   = 2'd2
	} reg_idx_t;

	typedef logic [REG_W-1:0]  reg_t;
	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [DEN_W-1:0]  den_t;
	typedef logic [Q_W-1:0]    quo_t;
	typedef logic [SIDE_W-1:0] side_t;

	typedef struct packed {
		reg_t strip_width;
		reg_t pixel_size;
		reg_t norm_gain;
	} cfg_t;

	typedef struct packed {
		reg_t brk;
		reg_t dmx;
		reg_t peak;
		logic neg_a;
		logic ovf_a;
		logic neg_b;
		logic ovf_b;
	} edge_side_t;

	typedef struct packed {
		logic [RPAD_W-1:0] pad;
		reg_t              peak;
		logic [FLAT_W-1:0] flat;
	} ramp_side_t;

	// one restoring step: remainder in the top DEN_W bits, quotient shifts in at the bottom
	function automatic num_t div_step(input num_t w, input den_t d);
		logic [DEN_W:0] t;
		logic           qb;
		t  = w[NUM_W-1:NUM_W-DEN_W-1];
		qb = 1'b0;
		if (t >= {1'b0, d}) begin
			t  = t - {1'b0, d};
			qb = 1'b1;
		end
		return {t[DEN_W-1:0], w[NUM_W-DEN_W-2:0], qb};
	endfunction

endpackage

// ===== src/tsi_cfg_regs.sv =====
// tsi_cfg_regs: strip width, pixel size and norm gain registers.
// Depends on tsi_pkg.
module tsi_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tsi_pkg::IDX_W-1:0]  cfg_index,
	input  tsi_pkg::reg_t              cfg_data,
	output tsi_pkg::cfg_t              cfg
);
	import tsi_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strip_width <= REG_RESET;
			cfg_q.pixel_size  <= REG_RESET;
			cfg_q.norm_gain   <= REG_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STRIP_WIDTH: cfg_q.strip_width <= cfg_data;
				REG_PIXEL_SIZE:  cfg_q.pixel_size  <= cfg_data;
				REG_NORM_GAIN:   cfg_q.norm_gain   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/tsi_div_pair.sv =====
// tsi_div_pair: two pipelined restoring dividers, one quotient bit per stage,
// with a sideband that travels alongside. Needs num < den * 2^Q_W. Depends on tsi_pkg.
module tsi_div_pair (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  tsi_pkg::num_t  in_num0,
	input  tsi_pkg::num_t  in_num1,
	input  tsi_pkg::den_t  in_den0,
	input  tsi_pkg::den_t  in_den1,
	input  tsi_pkg::side_t in_side,
	output logic           out_valid,
	output tsi_pkg::quo_t  out_quo0,
	output tsi_pkg::quo_t  out_quo1,
	output tsi_pkg::side_t out_side
);
	import tsi_pkg::*;

	logic [Q_W:0] vld_sn;
	num_t         w0_sn [0:Q_W];
	num_t         w1_sn [0:Q_W];
	den_t         d0_sn [0:Q_W];
	den_t         d1_sn [0:Q_W];
	side_t        side_sn [0:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn[0] <= 1'b0;
		end else begin
			vld_sn[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		w0_sn[0]   <= in_num0;
		w1_sn[0]   <= in_num1;
		d0_sn[0]   <= in_den0;
		d1_sn[0]   <= in_den1;
		side_sn[0] <= in_side;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k+1] <= 1'b0;
			end else begin
				vld_sn[k+1] <= vld_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			w0_sn[k+1]   <= div_step(w0_sn[k], d0_sn[k]);
			w1_sn[k+1]   <= div_step(w1_sn[k], d1_sn[k]);
			d0_sn[k+1]   <= d0_sn[k];
			d1_sn[k+1]   <= d1_sn[k];
			side_sn[k+1] <= side_sn[k];
		end
	end

	assign out_valid = vld_sn[Q_W];
	assign out_quo0  = w0_sn[Q_W][Q_W-1:0];
	assign out_quo1  = w1_sn[Q_W][Q_W-1:0];
	assign out_side  = side_sn[Q_W];

endmodule

// ===== src/trapezoid_strip_integral_unit.sv =====
// trapezoid_strip_integral_unit: integral of a trapezoid footprint over one strip.
// Depends on tsi_pkg, tsi_cfg_regs and tsi_div_pair.
//
// Usage:
//   Requests enter through start with center_offset, break_distance,
//   max_distance and peak_length; a request is taken when start is high and
//   busy is low. busy stays low: a request is taken every cycle.
//   Each result appears on strip_value for one cycle with done high;
//   results leave in request order. A request passes through two divider
//   pipelines of 32 register stages each (an input register, then 31 steps
//   of one quotient bit; edges into pixel units, then the ramp quotient),
//   plus the input, edge sign and saturation, clipping, squaring, product,
//   sum, gain and saturation stages.
//   Throughput: one request per cycle, sustained.
//   The receiver cannot stall; nothing is held back.
//   Configuration: cfg_we, cfg_index, cfg_data write strip_width (0),
//   pixel_size (1) and norm_gain (2); write only while no request is in flight.
//   Reset clears the pipeline valid bits and loads 1.0 into all three registers.
module trapezoid_strip_integral_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [tsi_pkg::DATA_WIDTH-1:0] center_offset,
	input  tsi_pkg::reg_t                       break_distance,
	input  tsi_pkg::reg_t                       max_distance,
	input  tsi_pkg::reg_t                       peak_length,
	output logic                                done,
	output logic signed [tsi_pkg::DATA_WIDTH-1:0] strip_value,
	input  logic                                cfg_we,
	input  logic [tsi_pkg::IDX_W-1:0]           cfg_index,
	input  tsi_pkg::reg_t                       cfg_data
);
	import tsi_pkg::*;

	localparam int EW = DATA_WIDTH + 2;
	localparam int CW = DATA_WIDTH + 1;

	cfg_t cfg;

	tsi_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign busy = 1'b0;

	// s1: input request
	logic                         v_s1;
	logic signed [DATA_WIDTH-1:0] off_s1;
	reg_t                         brk_s1, dmx_s1, peak_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		off_s1  <= center_offset;
		brk_s1  <= break_distance;
		dmx_s1  <= max_distance;
		peak_s1 <= peak_length;
	end

	// strip edges: |offset -/+ half| << FRAC_BITS, overflow test against pixel size
	logic signed [EW-1:0] half, off_x, na, nb;
	logic [EW-1:0]        mag_a, mag_b;
	num_t                 sh_a, sh_b, lim, num_a, num_b;
	den_t                 dpx;
	logic                 ovf_a, ovf_b;
	edge_side_t           eside;

	always_comb begin
		half  = EW'(cfg.strip_width[REG_W-1:1]);
		off_x = EW'(off_s1);
		na    = off_x - half;
		nb    = off_x + half;
		mag_a = na[EW-1] ? EW'(-na) : EW'(na);
		mag_b = nb[EW-1] ? EW'(-nb) : EW'(nb);
		sh_a  = NUM_W'(mag_a) << FRAC_BITS;
		sh_b  = NUM_W'(mag_b) << FRAC_BITS;
		dpx   = (cfg.pixel_size == '0) ? DEN_W'(1) : cfg.pixel_size;
		lim   = NUM_W'(dpx) << Q_W;
		ovf_a = sh_a >= lim;
		ovf_b = sh_b >= lim;
		num_a = ovf_a ? '0 : sh_a;
		num_b = ovf_b ? '0 : sh_b;
		eside.brk   = brk_s1;
		eside.dmx   = dmx_s1;
		eside.peak  = peak_s1;
		eside.neg_a = na[EW-1];
		eside.ovf_a = ovf_a;
		eside.neg_b = nb[EW-1];
		eside.ovf_b = ovf_b;
	end

	logic       ev_d;
	quo_t       qa_d, qb_d;
	side_t      eside_raw;
	edge_side_t eside_d;

	tsi_div_pair u_div_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_num0   (num_a),
		.in_num1   (num_b),
		.in_den0   (dpx),
		.in_den1   (dpx),
		.in_side   (side_t'(eside)),
		.out_valid (ev_d),
		.out_quo0  (qa_d),
		.out_quo1  (qb_d),
		.out_side  (eside_raw)
	);

	assign eside_d = edge_side_t'(eside_raw);

	// s2: signed, saturated edges
	logic                         v_s2;
	logic signed [DATA_WIDTH-1:0] a_s2, b_s2;
	reg_t                         brk_s2, dmx_s2, peak_s2;
	logic signed [DATA_WIDTH-1:0] qa_x, qb_x;

	assign qa_x = DATA_WIDTH'(qa_d);
	assign qb_x = DATA_WIDTH'(qb_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ev_d;
		end
	end

	always_ff @(posedge clk) begin
		a_s2    <= eside_d.ovf_a ? (eside_d.neg_a ? SMIN_D : SMAX_D)
		                         : (eside_d.neg_a ? -qa_x : qa_x);
		b_s2    <= eside_d.ovf_b ? (eside_d.neg_b ? SMIN_D : SMAX_D)
		                         : (eside_d.neg_b ? -qb_x : qb_x);
		brk_s2  <= eside_d.brk;
		dmx_s2  <= eside_d.dmx;
		peak_s2 <= eside_d.peak;
	end

	// s3: clip to rising ramp, flat top, falling ramp
	logic signed [CW-1:0] a_c, b_c, brk_c, dmx_c, den_c;
	logic signed [CW-1:0] lo_r, hi_r, lo_f, hi_f, lo_t, hi_t;
	logic signed [CW-1:0] u_r, v_r, u_f, v_f, wd_t;
	logic                 en_r, en_f, en_t;

	always_comb begin
		a_c   = CW'(a_s2);
		b_c   = CW'(b_s2);
		brk_c = CW'({2'b00, brk_s2});
		dmx_c = CW'({2'b00, dmx_s2});
		den_c = dmx_c - brk_c;
		lo_r  = (a_c > -dmx_c) ? a_c : -dmx_c;
		hi_r  = (b_c < -brk_c) ? b_c : -brk_c;
		en_r  = (hi_r > lo_r) && (den_c > 0);
		u_r   = hi_r + dmx_c;
		v_r   = lo_r + dmx_c;
		lo_t  = (a_c > -brk_c) ? a_c : -brk_c;
		hi_t  = (b_c < brk_c) ? b_c : brk_c;
		en_t  = hi_t > lo_t;
		wd_t  = hi_t - lo_t;
		lo_f  = (a_c > brk_c) ? a_c : brk_c;
		hi_f  = (b_c < dmx_c) ? b_c : dmx_c;
		en_f  = (hi_f > lo_f) && (den_c > 0);
		u_f   = dmx_c - lo_f;
		v_f   = dmx_c - hi_f;
	end

	logic             v_s3;
	reg_t             ur_s3, vr_s3, uf_s3, vf_s3, den_s3, peak_s3;
	logic [WID_W-1:0] wid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ur_s3   <= en_r ? u_r[REG_W-1:0] : '0;
		vr_s3   <= en_r ? v_r[REG_W-1:0] : '0;
		uf_s3   <= en_f ? u_f[REG_W-1:0] : '0;
		vf_s3   <= en_f ? v_f[REG_W-1:0] : '0;
		wid_s3  <= en_t ? wd_t[WID_W-1:0] : '0;
		den_s3  <= (den_c > 0) ? den_c[REG_W-1:0] : REG_W'(1);
		peak_s3 <= peak_s2;
	end

	// s4: squares and flat area
	logic                   v_s4;
	num_t                   uur_s4, vvr_s4, uuf_s4, vvf_s4;
	logic [FLAT_W-1:0]      flat_s4;
	reg_t                   den_s4, peak_s4;
	logic [REG_W+WID_W-1:0] fprod;

	assign fprod = peak_s3 * wid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		uur_s4  <= ur_s3 * ur_s3;
		vvr_s4  <= vr_s3 * vr_s3;
		uuf_s4  <= uf_s3 * uf_s3;
		vvf_s4  <= vf_s3 * vf_s3;
		flat_s4 <= fprod[REG_W+WID_W-1:FRAC_BITS];
		den_s4  <= den_s3;
		peak_s4 <= peak_s3;
	end

	ramp_side_t rside, rside_d;
	side_t      rside_raw;
	logic       rv_d;
	quo_t       qr_d, qf_d;

	always_comb begin
		rside.pad  = '0;
		rside.peak = peak_s4;
		rside.flat = flat_s4;
	end

	tsi_div_pair u_div_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_num0   (uur_s4 - vvr_s4),
		.in_num1   (uuf_s4 - vvf_s4),
		.in_den0   (den_s4),
		.in_den1   (den_s4),
		.in_side   (side_t'(rside)),
		.out_valid (rv_d),
		.out_quo0  (qr_d),
		.out_quo1  (qf_d),
		.out_side  (rside_raw)
	);

	assign rside_d = ramp_side_t'(rside_raw);

	// s6: ramp areas
	logic              v_s6;
	num_t              pr_s6, pf_s6;
	logic [FLAT_W-1:0] flat_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		pr_s6   <= rside_d.peak * qr_d;
		pf_s6   <= rside_d.peak * qf_d;
		flat_s6 <= rside_d.flat;
	end

	// s7: sum of pieces
	logic             v_s7;
	logic [SUM_W-1:0] sum_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		sum_s7 <= SUM_W'(pr_s6[NUM_W-1:FRAC_BITS+1]) + SUM_W'(pf_s6[NUM_W-1:FRAC_BITS+1])
		        + SUM_W'(flat_s6);
	end

	// s8: gain, split into high and low parts of the sum
	logic                             v_s8;
	logic [SUM_W-FRAC_BITS+REG_W-1:0] hp_s8;
	logic [FRAC_BITS+REG_W-1:0]       lp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		hp_s8 <= sum_s7[SUM_W-1:FRAC_BITS] * cfg.norm_gain;
		lp_s8 <= sum_s7[FRAC_BITS-1:0] * cfg.norm_gain;
	end

	// s9: combine and saturate
	localparam int RW = SUM_W - FRAC_BITS + REG_W + 1;

	logic [RW-1:0]                res;
	logic                         v_s9;
	logic signed [DATA_WIDTH-1:0] val_s9;

	assign res = RW'(hp_s8) + RW'(lp_s8[FRAC_BITS+REG_W-1:FRAC_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		val_s9 <= (res > RW'(SMAX_D)) ? SMAX_D : res[DATA_WIDTH-1:0];
	end

	assign done        = v_s9;
	assign strip_value = val_s9;

endmodule
